// ----- hw/rtl/ple_pkg.sv -----
package ple_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned OpW    = 4;

  typedef enum logic [OpW-1:0] {
    OP_INSERT_AT   = 4'd0,
    OP_INSERT_HEAD = 4'd1,
    OP_INSERT_TAIL = 4'd2,
    OP_DELETE      = 4'd3,
    OP_GET         = 4'd4,
    OP_LOCATE      = 4'd5,
    OP_PRIOR       = 4'd6,
    OP_NEXT        = 4'd7,
    OP_CLEAR       = 4'd8
  } op_e;

  // broadcast from the sequencer to every cell of the row
  typedef struct packed {
    logic             capture;   // latch compare result against value
    logic             shift_in;  // open a gap at pos and drop value into it
    logic             shift_out; // close the gap at pos
    logic [WordW-1:0] value;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/positional_list_engine_unit.sv -----
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------------
// request  | in_valid_i/in_stall_o | op_i, position_i, value_i
// response | out_valid_o/out_stall_i | ok_o, result_value_o, found_index_o, length_o,
//          |                       | is_empty_o
//
// each request passes through the sequencer in order: capture (every cell compares),
// select (first-match or position decode), execute (row shifts, result registered).
// a new request is taken only once the previous one has left execute, so requests
// never overlap in the sequencer.
// execute waits while an earlier response still sits stalled in the output register.
// reset empties the list at once; entry contents are not cleared.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  op_i,
  input  logic [5:0]  position_i,
  input  logic signed [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic signed [31:0] result_value_o,
  output logic signed [5:0]  found_index_o,
  output logic [5:0]  length_o,
  output logic        is_empty_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > ple_pkg::PosW) ? CW : ple_pkg::PosW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SEL  = 4'b0010,
    S_EXEC = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  ple_pkg::op_e              op_q;
  logic [ple_pkg::PosW-1:0]  pos_q;
  logic [ple_pkg::WordW-1:0] val_q;
  logic [CW-1:0]             count_q, count_d;
  logic [CAPACITY-1:0]       sel_q, sel_d;
  logic                      found_q;

  logic                      out_valid_q;
  logic                      ok_q;
  logic [ple_pkg::WordW-1:0] res_q;
  logic [5:0]                fidx_q;
  logic [5:0]                len_q;
  logic                      empty_q;

  logic                      in_xfer;
  logic                      exec_fire;
  logic [CAPACITY-1:0]       match_v;
  logic [CAPACITY-1:0]       live_v;
  logic [CAPACITY-1:0]       posdec;
  logic [CAPACITY-1:0]       tap;
  logic [CAPACITY-1:0]       tap_live;
  logic [ple_pkg::WordW-1:0] entry_w [CAPACITY];
  logic [ple_pkg::WordW-1:0] rd;
  logic [XW-1:0]             idx;
  logic [XW-1:0]             pos_x;
  logic [XW-1:0]             count_x;
  logic [XW-1:0]             pos_eff;
  logic                      full;
  logic                      ins_ok;
  logic                      del_ok;
  logic                      ok_d;
  logic [ple_pkg::WordW-1:0] res_d;
  logic [XW-1:0]             fidx_d;
  ple_pkg::cell_cmd_t        cmd;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  // execute may finish when the output register is free or being drained
  assign exec_fire  = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  assign pos_x   = XW'(pos_q);
  assign count_x = XW'(count_q);
  assign full    = (count_q == CW'(CAPACITY));

  always_comb begin
    pos_eff = pos_x;
    ins_ok  = 1'b0;
    del_ok  = 1'b0;
    case (op_q)
      ple_pkg::OP_INSERT_AT: ins_ok = !full && (pos_x <= count_x);
      ple_pkg::OP_INSERT_HEAD: begin
        ins_ok  = !full;
        pos_eff = '0;
      end
      ple_pkg::OP_INSERT_TAIL: begin
        ins_ok  = !full;
        pos_eff = count_x;
      end
      ple_pkg::OP_DELETE: del_ok = (pos_x < count_x);
      default: ;
    endcase
  end

  assign cmd.capture   = in_xfer;
  assign cmd.shift_in  = exec_fire && ins_ok;
  assign cmd.shift_out = exec_fire && del_ok;
  assign cmd.value     = in_xfer ? value_i : val_q;

  // row of cells, each handing its word to its neighbors when the row shifts
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ple_pkg::WordW-1:0] left_w;
    logic [ple_pkg::WordW-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = entry_w[g];
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end
    ple_cell #(
      .XW  (XW),
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .pos_i   (pos_eff),
      .count_i (count_x),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[g]),
      .match_o (match_v[g]),
      .live_o  (live_v[g])
    );
    assign posdec[g] = (XW'(g) == pos_x);
  end

  // select: lowest set match bit, or the addressed cell
  always_comb begin
    if (op_q == ple_pkg::OP_GET || op_q == ple_pkg::OP_DELETE) begin
      sel_d = posdec;
    end else begin
      sel_d = match_v & ~(match_v - CAPACITY'(1));
    end
  end

  always_comb begin
    case (op_q)
      ple_pkg::OP_PRIOR: tap = sel_q >> 1;
      ple_pkg::OP_NEXT:  tap = sel_q << 1;
      default:           tap = sel_q;
    endcase
  end
  assign tap_live = tap & live_v;

  always_comb begin
    rd  = '0;
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tap_live[i]) begin
        rd = rd | entry_w[i];
      end
      if (sel_q[i]) begin
        idx = idx | XW'(i);
      end
    end
  end

  always_comb begin
    ok_d    = 1'b0;
    res_d   = '0;
    fidx_d  = '1;
    count_d = count_q;
    case (op_q)
      ple_pkg::OP_INSERT_AT, ple_pkg::OP_INSERT_HEAD, ple_pkg::OP_INSERT_TAIL: begin
        ok_d = ins_ok;
        if (ins_ok) begin
          count_d = count_q + CW'(1);
        end
      end
      ple_pkg::OP_DELETE: begin
        ok_d  = del_ok;
        res_d = rd;
        if (del_ok) begin
          count_d = count_q - CW'(1);
        end
      end
      ple_pkg::OP_GET, ple_pkg::OP_PRIOR, ple_pkg::OP_NEXT: begin
        ok_d  = |tap_live;
        res_d = rd;
      end
      ple_pkg::OP_LOCATE: begin
        ok_d = found_q;
        if (found_q) begin
          fidx_d = idx;
        end
      end
      ple_pkg::OP_CLEAR: begin
        ok_d    = 1'b1;
        count_d = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_xfer) state_d = S_SEL;
      S_SEL:  state_d = S_EXEC;
      S_EXEC: if (exec_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= ple_pkg::op_e'(op_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (state_q == S_SEL) begin
      sel_q   <= sel_d;
      found_q <= |match_v;
    end
    if (exec_fire) begin
      ok_q    <= ok_d;
      res_q   <= res_d;
      fidx_q  <= fidx_d[5:0];
      len_q   <= XW'(count_d) >> 0 == '0 ? 6'd0 : 6'(XW'(count_d));
      empty_q <= (count_d == '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign result_value_o = res_q;
  assign found_index_o  = fidx_q;
  assign length_o       = len_q;
  assign is_empty_o     = empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> $onehot0(sel_q))
    else $error("more than one cell selected");

  a_found_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && op_q == ple_pkg::OP_LOCATE && found_q) |-> $onehot(sel_q))
    else $error("match seen but no cell selected");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && ins_ok) |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && del_ok) |=> count_q + CW'(1) == $past(count_q))
    else $error("delete did not shrink the list");

endmodule

// ----- hw/rtl/ple_cell.sv -----
module ple_cell #(
  parameter int unsigned XW  = 6,
  parameter int unsigned IDX = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ple_pkg::cell_cmd_t      cmd_i,
  input  logic [XW-1:0]           pos_i,
  input  logic [XW-1:0]           count_i,
  input  logic [ple_pkg::WordW-1:0] left_i,
  input  logic [ple_pkg::WordW-1:0] right_i,
  output logic [ple_pkg::WordW-1:0] entry_o,
  output logic                    match_o,
  output logic                    live_o
);

  localparam logic [XW-1:0] IdxX = XW'(IDX);

  logic [ple_pkg::WordW-1:0] entry_q, entry_d;
  logic                      match_q;
  logic                      live;

  assign live = (IdxX < count_i);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.shift_in) begin
      if (IdxX == pos_i) begin
        entry_d = cmd_i.value;
      end else if (IdxX > pos_i) begin
        entry_d = left_i;
      end
    end else if (cmd_i.shift_out) begin
      if (IdxX >= pos_i) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (cmd_i.capture) begin
      match_q <= live && (entry_q == cmd_i.value);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;
  assign live_o  = live;

endmodule
